### src/sris_pkg.sv
// Shared types and constants for the sorted row insertion search core.
package sris_pkg;

    localparam int MaxRow   = 64;
    localparam int AddrW    = $clog2(MaxRow);
    localparam int LenW     = 7;
    localparam int ValW     = 32;
    localparam int QueueDepth = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [0:0] REG_RIGHT_SIDE = 1'd0;
    localparam logic [0:0] REG_ROW_LENGTH = 1'd1;

    // Classified command passed from front to back
    typedef struct packed {
        logic             is_query;
        logic [AddrW-1:0] addr;
        logic [ValW-1:0]  value;
    } cmd_t;

    // Scan test: does the query pass against the entry
    function automatic logic passes(input logic [ValW-1:0] q, input logic [ValW-1:0] e,
                                    input logic right);
        logic       q_nan;
        logic       e_nan;
        logic [ValW-1:0] kq;
        logic [ValW-1:0] ke;
        q_nan = (q[30:0] > 31'h7F800000);
        e_nan = (e[30:0] > 31'h7F800000);
        if (q[30:0] == 31'd0)
            kq = 32'h80000000;
        else if (q[31])
            kq = ~q;
        else
            kq = q | 32'h80000000;
        if (e[30:0] == 31'd0)
            ke = 32'h80000000;
        else if (e[31])
            ke = ~e;
        else
            ke = e | 32'h80000000;
        if (q_nan || e_nan)
            passes = 1'b0;
        else if (right)
            passes = (kq >= ke);
        else
            passes = (kq > ke);
    endfunction

endpackage

### src/sris_front.sv
// Front end: takes input transfers, tracks the load pointer, classifies items.
module sris_front
    import sris_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  logic            operation,
    input  logic [ValW-1:0] value,
    input  logic [LenW-1:0] eff_len,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output cmd_t            cmd
);

    logic [LenW-1:0] ptr_reg;
    logic [LenW-1:0] ptr_next;
    logic            accept;
    logic            keep;

    assign ready = cmd_ready;
    assign accept = valid && ready;

    // Loads past the row end and queries on an empty row are dropped
    always_comb
    begin
        if (operation == OP_LOAD)
            keep = (ptr_reg < eff_len);
        else
            keep = (eff_len != '0);
    end

    assign cmd_valid    = accept && keep;
    assign cmd.is_query = (operation == OP_QUERY);
    assign cmd.addr     = ptr_reg[AddrW-1:0];
    assign cmd.value    = value;

    // Load pointer
    always_comb
    begin
        ptr_next = ptr_reg;
        if (accept)
        begin
            if (operation == OP_QUERY)
                ptr_next = '0;
            else if (keep)
                ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else
            ptr_reg <= ptr_next;
    end

endmodule

### src/sris_queue.sv
// Short command queue between the front and back ends.
module sris_queue
    import sris_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PtrW = $clog2(QueueDepth);

    cmd_t            slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_reg;
    logic [PtrW-1:0] rd_reg;
    logic [PtrW:0]   count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != QueueDepth[PtrW:0]);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= in_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
        end
    end

endmodule

### src/sris_back.sv
// Back end: row memory writes and the slot-by-slot query scan.
module sris_back
    import sris_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  cmd_t            cmd,
    input  logic            right_side,
    input  logic [LenW-1:0] eff_len,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [LenW-1:0] position
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_OUT   = 3'b100
    } state_t;

    logic [ValW-1:0] mem [MaxRow];
    logic [ValW-1:0] rd_data_reg;
    logic [ValW-1:0] query_reg;
    logic [LenW-1:0] idx_reg;
    logic [LenW-1:0] rd_idx_reg;
    logic            rd_pend_reg;
    logic [LenW-1:0] pos_reg;
    state_t          state_reg;
    logic            start;
    logic            issue;
    logic            last_issue;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign start     = cmd_valid && cmd_ready && cmd.is_query;
    assign issue     = (state_reg == ST_SCAN) && (idx_reg < eff_len);
    assign last_issue = 1'b0;
    assign out_valid = (state_reg == ST_OUT);
    assign position  = pos_reg;

    // Row memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && !cmd.is_query)
            mem[cmd.addr] <= cmd.value;
        if (start)
            rd_data_reg <= mem['0];
        else
            rd_data_reg <= mem[idx_reg[AddrW-1:0]];
        if (start)
            query_reg <= cmd.value;
    end

    // Scan: one slot read issued per cycle, tested the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg   <= ST_SCAN;
                        idx_reg     <= 7'd1;
                        rd_idx_reg  <= '0;
                        rd_pend_reg <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_pend_reg && !passes(query_reg, rd_data_reg, right_side))
                    begin
                        pos_reg   <= rd_idx_reg;
                        state_reg <= ST_OUT;
                    end
                    else if (!issue && rd_pend_reg && (rd_idx_reg + 1'b1 >= eff_len))
                    begin
                        pos_reg   <= eff_len;
                        state_reg <= ST_OUT;
                    end
                    else if (issue)
                    begin
                        rd_idx_reg  <= idx_reg;
                        rd_pend_reg <= 1'b1;
                        idx_reg     <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        pos_reg   <= eff_len;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready && !last_issue)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/sorted_row_insertion_search_core.sv
// Top level of the sorted row insertion search core.
// A load transfer writes the next row slot; loads past the row end are
// dropped. A query scans slots from 0 through the registered read port of the row
// memory, one slot per cycle, and returns the first failing slot or the row length.
// A two-entry command queue lets loads and queries be taken while a scan or a
// result is still pending.
module sorted_row_insertion_search_core
    import sris_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  logic            operation,
    input  logic [ValW-1:0] value,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [LenW-1:0] position,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [LenW-1:0] cfg_data
);

    logic            right_side_reg;
    logic [LenW-1:0] row_length_reg;
    logic [LenW-1:0] eff_len;
    logic            f_valid;
    logic            f_ready;
    cmd_t            f_cmd;
    logic            q_valid;
    logic            q_ready;
    cmd_t            q_cmd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_side_reg <= 1'b0;
            row_length_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RIGHT_SIDE: right_side_reg <= cfg_data[0];
                REG_ROW_LENGTH: row_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_len = (row_length_reg > LenW'(MaxRow)) ? LenW'(MaxRow) : row_length_reg;

    sris_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
        .operation(operation), .value(value), .eff_len(eff_len),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    sris_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    sris_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .right_side(right_side_reg), .eff_len(eff_len),
        .out_valid(out_valid), .out_ready(out_ready), .position(position)
    );

endmodule

### tb/sv/sorted_row_insertion_search_core_test.sv
// Self-checking testbench for the sorted row insertion search core.
module sorted_row_insertion_search_core_test;
    import sris_pkg::*;

    logic            clk;
    logic            rst_n;
    logic            valid;
    logic            ready;
    logic            operation;
    logic [ValW-1:0] value;
    logic            out_valid;
    logic            out_ready;
    logic [LenW-1:0] position;
    logic            cfg_we;
    logic [0:0]      cfg_index;
    logic [LenW-1:0] cfg_data;

    sorted_row_insertion_search_core u_top (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
        .operation(operation), .value(value), .out_valid(out_valid),
        .out_ready(out_ready), .position(position), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Directed stimulus row; exp_pos < 0 means use the predictor
    typedef struct {
        logic            op;
        logic [ValW-1:0] val;
        int              exp_pos;
    } stim_row_t;

    // Predictor state
    logic [ValW-1:0] row_mem [MaxRow];
    bit              row_written [MaxRow];
    int              load_ptr;
    logic            mode_right;
    int              row_len;

    logic [LenW-1:0] pending_pos [$];
    int  mismatches;
    int  stall_cycles;
    bit  timed_out;
    bit  long_hold;
    bit  stim_done;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // IEEE ordering test for one slot
    function automatic bit slot_passes(logic [ValW-1:0] q, logic [ValW-1:0] e, logic rs);
        logic [ValW-1:0] kq;
        logic [ValW-1:0] ke;
        if (q[30:0] > 31'h7F800000 || e[30:0] > 31'h7F800000)
            return 0;
        kq = (q[30:0] == 0) ? 32'h80000000 : (q[31] ? ~q : (q | 32'h80000000));
        ke = (e[30:0] == 0) ? 32'h80000000 : (e[31] ? ~e : (e | 32'h80000000));
        return rs ? (kq >= ke) : (kq > ke);
    endfunction

    // Update predictor for one accepted transfer; returns computed position or -1
    function automatic int predict_search(logic op, logic [ValW-1:0] v);
        int j;
        if (op == OP_LOAD)
        begin
            if (load_ptr < row_len)
            begin
                row_mem[load_ptr] = v;
                row_written[load_ptr] = 1;
                load_ptr++;
            end
            return -1;
        end
        load_ptr = 0;
        if (row_len == 0)
            return -1;
        for (j = 0; j < row_len; j++)
            if (!slot_passes(v, row_mem[j], mode_right))
                break;
        return j;
    endfunction

    // Send one input transfer after a random gap
    task automatic send_item(logic op, logic [ValW-1:0] v, int exp_pos);
        int gap;
        int pos;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid     <= 1'b1;
        operation <= op;
        value     <= v;
        do @(posedge clk); while (!ready);
        pos = predict_search(op, v);
        if (exp_pos >= 0 && pos != exp_pos)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row: predictor %0d, table %0d", pos, exp_pos);
        end
        if (pos >= 0)
            pending_pos.push_back(pos[LenW-1:0]);
    endtask

    // Configuration write while idle
    task automatic write_cfg(logic [0:0] idx, logic [LenW-1:0] d);
        valid <= 1'b0;
        wait (pending_pos.size() == 0);
        repeat (70) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_RIGHT_SIDE)
            mode_right = d[0];
        else
            row_len = (d > MaxRow) ? MaxRow : d;
    endtask

    // Random float pattern biased to interesting values
    function automatic logic [ValW-1:0] rand_float();
        case ($urandom_range(0, 9))
            0: return 32'h00000000;
            1: return 32'h80000000;
            2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 8388607))};
            3: return {$urandom_range(0, 1) == 1, 31'h7F800000};
            4: return 32'($urandom_range(0, 7)) << 28;
            default: return $urandom();
        endcase
    endfunction

    // Load a full sorted row then query; sorted by float order
    task automatic send_row(int n);
        logic [ValW-1:0] r [$];
        logic [ValW-1:0] t;
        int i;
        int k;
        for (i = 0; i < n; i++)
            r.push_back(($urandom_range(0, 7) == 0) ? rand_float() : {1'b0, 31'($urandom())});
        for (i = 0; i < n; i++)
            for (k = 0; k + 1 < n - i; k++)
                if (slot_passes(r[k], r[k + 1], 1'b0))
                begin
                    t = r[k];
                    r[k] = r[k + 1];
                    r[k + 1] = t;
                end
        for (i = 0; i < n; i++)
            send_item(OP_LOAD, r[i], -1);
        for (i = 0; i < $urandom_range(1, 3); i++)
            send_item(OP_QUERY, ($urandom_range(0, 2) == 0 && n > 0) ?
                      r[$urandom_range(0, n - 1)] : rand_float(), -1);
    endtask

    // Stimulus
    initial
    begin
        stim_row_t dir [$];
        int i;
        int count;
        int len;
        rst_n = 1'b0;
        valid = 1'b0;
        operation = OP_LOAD;
        value = '0;
        cfg_we = 1'b0;
        cfg_index = REG_RIGHT_SIDE;
        cfg_data = '0;
        mismatches = 0;
        stim_done = 0;
        load_ptr = 0;
        mode_right = 1'b0;
        row_len = MaxRow;
        for (i = 0; i < MaxRow; i++)
            row_written[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: row of length 4 with signed zero, infinities and NaN
        write_cfg(REG_ROW_LENGTH, 7'd4);
        dir = '{
            '{OP_LOAD,  32'hFF800000, -1},
            '{OP_LOAD,  32'h80000000, -1},
            '{OP_LOAD,  32'h3F800000, -1},
            '{OP_LOAD,  32'h7F800000, -1},
            '{OP_LOAD,  32'hFFFFFFFF, -1},
            '{OP_QUERY, 32'h00000000, 1},
            '{OP_QUERY, 32'hFF800000, 0},
            '{OP_QUERY, 32'h7FC00000, 0},
            '{OP_QUERY, 32'h7F800000, 3},
            '{OP_QUERY, 32'h3F800000, 2}
        };
        foreach (dir[i])
            send_item(dir[i].op, dir[i].val, dir[i].exp_pos);
        write_cfg(REG_RIGHT_SIDE, 7'd1);
        dir = '{
            '{OP_QUERY, 32'h00000000, 2},
            '{OP_QUERY, 32'h7F800000, 4},
            '{OP_QUERY, 32'hFF800000, 1},
            '{OP_QUERY, 32'hFFC00001, 0},
            '{OP_LOAD,  32'h7F800001, -1},
            '{OP_QUERY, 32'h7F800000, 0}
        };
        foreach (dir[i])
            send_item(dir[i].op, dir[i].val, dir[i].exp_pos);
        // Row length extremes
        write_cfg(REG_ROW_LENGTH, 7'd1);
        send_item(OP_LOAD, 32'h00000001, -1);
        send_item(OP_LOAD, 32'h00000002, -1);
        send_item(OP_QUERY, 32'h00000001, 1);
        write_cfg(REG_ROW_LENGTH, 7'd64);
        send_row(64);
        write_cfg(REG_ROW_LENGTH, 7'd127);
        send_row(64);
        send_item(OP_LOAD, 32'hFFFFFFFF, -1);
        send_item(OP_QUERY, 32'h7FFFFFFF, 0);
        write_cfg(REG_ROW_LENGTH, 7'd0);
        send_item(OP_LOAD, 32'h12345678, -1);
        send_item(OP_QUERY, 32'h00000000, -1);
        write_cfg(REG_ROW_LENGTH, 7'd64);
        write_cfg(REG_RIGHT_SIDE, 7'd0);
        send_row(64);

        // Random phases
        count = 0;
        while (count < 2000)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                len = ($urandom_range(0, 5) == 0) ? MaxRow : $urandom_range(1, 12);
                write_cfg(REG_ROW_LENGTH, len[LenW-1:0]);
                write_cfg(REG_RIGHT_SIDE, LenW'($urandom_range(0, 1)));
                send_row(row_len);
                count += row_len + 1;
            end
            len = $urandom_range(0, row_len);
            if ($urandom_range(0, 4) == 0)
            begin
                // Noise: extra loads over the start of the row and a query on the partly overwritten row
                for (i = 0; i < $urandom_range(1, 4); i++)
                    send_item(OP_LOAD, rand_float(), -1);
                send_item(OP_QUERY, rand_float(), -1);
                count += 3;
            end
            else
            begin
                send_row(row_len);
                count += row_len + 2;
            end
        end
        valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls plus one long hold-off
    initial
    begin
        int hold;
        out_ready = 1'b0;
        long_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold && pending_pos.size() > 0)
            begin
                long_hold = 1;
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Result check
    always @(posedge clk)
    begin
        logic [LenW-1:0] exp_pos;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pos.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected position %0d", position);
            end
            else
            begin
                exp_pos = pending_pos.pop_front();
                if (position !== exp_pos)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("position mismatch: expected %0d, got %0d",
                                 exp_pos, position);
                end
            end
        end
    end

    // Watchdog and end of run
    initial
    begin
        stall_cycles = 0;
        timed_out = 0;
        while (!(stim_done && pending_pos.size() == 0) && !timed_out)
        begin
            @(posedge clk);
            if ((valid && ready) || (out_valid && out_ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles > 5000)
                timed_out = 1;
        end
        if (timed_out)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            repeat (100) @(posedge clk);
            if (mismatches == 0 && pending_pos.size() == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
            $finish;
        end
    end

endmodule

### sim.f
src/sris_pkg.sv
src/sris_front.sv
src/sris_queue.sv
src/sris_back.sv
src/sorted_row_insertion_search_core.sv
tb/sv/sorted_row_insertion_search_core_test.sv
